[hdl/ndf_pkg.sv]
// ----------------------------------------------------------------------------
// ndf_pkg - shared types and constants of the navigation frame deframer
// Header bytes, field layout table, channel payloads and state encodings.
// ----------------------------------------------------------------------------
package ndf_pkg;

   localparam logic [7:0] HDR0_BYTE = 8'h23;
   localparam logic [7:0] HDR1_BYTE = 8'h5A;
   localparam logic [7:0] HDR2_BYTE = 8'h48;
   localparam logic [7:0] HDR_XOR   = HDR0_BYTE ^ HDR1_BYTE ^ HDR2_BYTE;

   // header bytes are never read back, the first stored byte follows them
   localparam int HDR_BYTES = 3;

   localparam int NUM_FIELDS = 25;
   localparam logic [4:0] LAST_FIELD_INDEX = 5'(NUM_FIELDS - 1);

   // frame offset of each field; the fields lie back to back
   localparam logic [6:0] FIELD_OFFSET [NUM_FIELDS] = '{
      7'd5,  7'd6,  7'd7,  7'd15, 7'd23, 7'd27, 7'd31, 7'd35, 7'd39,
      7'd43, 7'd47, 7'd51, 7'd55, 7'd59, 7'd63, 7'd67, 7'd71,
      7'd75, 7'd79, 7'd81, 7'd82, 7'd83, 7'd84, 7'd85, 7'd86
   };

   // byte lane of the last byte of each field (size minus one)
   localparam logic [2:0] FIELD_LAST_LANE [NUM_FIELDS] = '{
      3'd0, 3'd0, 3'd7, 3'd7, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
   };

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [4:0]  field_index;
      logic [63:0] field_value;
      logic        checksum_error;
      logic        last_field;
   } rsp_payload_type;

   // finished frame handed from the front part to the back part
   typedef struct packed {
      logic bank;
      logic err;
   } frame_desc_type;

   // back part hands a frame bank back to the front part
   typedef struct packed {
      logic valid;
      logic bank;
   } bank_release_type;

   typedef enum logic [1:0] {
      FR_HUNT0,
      FR_HUNT1,
      FR_HUNT2,
      FR_COLLECT
   } front_state_type;

   typedef enum logic {
      BK_IDLE,
      BK_STREAM
   } back_state_type;

endpackage

[hdl/ndf_stream_if.sv]
// ----------------------------------------------------------------------------
// ndf_stream_if - valid/ready channel
// Carries one payload item per handshake; the payload type is a parameter.
// ----------------------------------------------------------------------------
interface ndf_stream_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (
      output valid,
      output data,
      input  ready
   );

   modport sink (
      input  valid,
      input  data,
      output ready
   );

endinterface

[hdl/ndf_ram.sv]
// ----------------------------------------------------------------------------
// ndf_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ndf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/ndf_front.sv]
// ----------------------------------------------------------------------------
// ndf_front - header hunt and frame collection
// Finds the header, writes frame bytes into the free bank, runs the XOR and
// posts a frame descriptor with the checksum verdict at the end of a frame.
// ----------------------------------------------------------------------------
module ndf_front import ndf_pkg::*; #(
   parameter int FRAME_BYTES   = 90,
   parameter int CHECKED_BYTES = 87
) (
   input  logic                             clock,
   input  logic                             reset,
   ndf_stream_if.sink                       req_if,
   output logic                             wr_en,
   output logic [$clog2(FRAME_BYTES):0]     wr_addr,
   output logic [7:0]                       wr_data,
   output logic                             push_en,
   output frame_desc_type                   push_desc,
   input  logic                             q_full,
   input  bank_release_type                 rel
);

   localparam int AW = $clog2(FRAME_BYTES);

   front_state_type state_ff, state_in;
   logic [AW-1:0]   pos_ff, pos_in;
   logic [7:0]      xor_ff, xor_in;
   logic [7:0]      chk_ff, chk_in;
   logic            wr_bank_ff, wr_bank_in;
   logic [1:0]      busy_ff, busy_in;

   logic       accept;
   logic [7:0] rx;
   logic       frame_end;
   logic [7:0] chk_val;

   assign rx        = req_if.data.rx_byte;
   assign accept    = req_if.valid && req_if.ready;
   assign frame_end = (pos_ff == AW'(FRAME_BYTES - 1));
   assign chk_val   = (pos_ff == AW'(CHECKED_BYTES)) ? rx : chk_ff;

   // hold off while the queue is full or the next bank is still being read
   assign req_if.ready = !q_full && !busy_ff[wr_bank_ff];

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         case (state_ff)
            FR_HUNT0: begin
               if (rx == HDR0_BYTE) state_in = FR_HUNT1;
            end
            FR_HUNT1: begin
               if (rx == HDR1_BYTE)      state_in = FR_HUNT2;
               else if (rx == HDR0_BYTE) state_in = FR_HUNT1;
               else                      state_in = FR_HUNT0;
            end
            FR_HUNT2: begin
               if (rx == HDR2_BYTE)      state_in = FR_COLLECT;
               else if (rx == HDR0_BYTE) state_in = FR_HUNT1;
               else                      state_in = FR_HUNT0;
            end
            FR_COLLECT: begin
               if (frame_end) state_in = FR_HUNT0;
            end
            default: state_in = FR_HUNT0;
         endcase
      end
   end

   always_comb begin
      pos_in     = pos_ff;
      xor_in     = xor_ff;
      chk_in     = chk_ff;
      wr_bank_in = wr_bank_ff;
      busy_in    = busy_ff;
      wr_en      = 1'b0;
      push_en    = 1'b0;
      push_desc  = '{bank: wr_bank_ff, err: (xor_ff != chk_val)};
      wr_addr    = {wr_bank_ff, pos_ff};
      wr_data    = rx;

      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end

      if (accept) begin
         case (state_ff)
            FR_HUNT2: begin
               // header bytes are folded into the XOR, not stored
               if (rx == HDR2_BYTE) begin
                  pos_in = AW'(HDR_BYTES);
                  xor_in = HDR_XOR;
               end
            end
            FR_COLLECT: begin
               wr_en  = 1'b1;
               pos_in = AW'(pos_ff + 1'b1);
               chk_in = chk_val;
               if (pos_ff < AW'(CHECKED_BYTES)) begin
                  xor_in = xor_ff ^ rx;
               end
               if (frame_end) begin
                  push_en = 1'b1;
                  if (!push_desc.err) begin
                     busy_in[wr_bank_ff] = 1'b1;
                     wr_bank_in          = !wr_bank_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FR_HUNT0;
         wr_bank_ff <= 1'b0;
         busy_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         wr_bank_ff <= wr_bank_in;
         busy_ff    <= busy_in;
      end
      pos_ff <= pos_in;
      xor_ff <= xor_in;
      chk_ff <= chk_in;
   end

endmodule

[hdl/ndf_fifo.sv]
// ----------------------------------------------------------------------------
// ndf_fifo - two-entry frame descriptor queue
// Decouples frame collection from field readout.
// ----------------------------------------------------------------------------
module ndf_fifo import ndf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_en,
   input  frame_desc_type push_desc,
   input  logic           pop_en,
   output frame_desc_type head,
   output logic           full,
   output logic           empty
);

   frame_desc_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           do_push;
   logic           do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push_en && !full;
   assign do_pop  = pop_en && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

[hdl/ndf_back.sv]
// ----------------------------------------------------------------------------
// ndf_back - field readout
// Streams a good frame's field bytes from its bank, when unstalled one byte a
// cycle, assembles each little-endian field and drives the result channel.
// ----------------------------------------------------------------------------
module ndf_back import ndf_pkg::*; #(
   parameter int FRAME_BYTES = 90
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  frame_desc_type                q_head,
   output logic                          q_pop,
   output logic [$clog2(FRAME_BYTES):0]  rd_addr,
   input  logic [7:0]                    rd_data,
   output bank_release_type              rel,
   ndf_stream_if.source                  rsp_if
);

   localparam int AW = $clog2(FRAME_BYTES);

   back_state_type  state_ff, state_in;
   logic            bank_ff, bank_in;
   logic [4:0]      k_ff, k_in;
   logic [2:0]      lane_ff, lane_in;
   logic            rd_v_ff, rd_v_in;
   logic [4:0]      cap_k_ff, cap_k_in;
   logic [2:0]      cap_lane_ff, cap_lane_in;
   logic            cap_last_ff, cap_last_in;
   logic [63:0]     acc_ff, acc_in;
   logic            done_v_ff, done_v_in;
   rsp_payload_type done_ff, done_in;
   logic            out_v_ff, out_v_in;
   rsp_payload_type out_ff, out_in;

   logic        out_take;
   logic        move;
   logic        room;
   logic        slot_claimed;
   logic        step;
   logic        issue;
   logic        byte_last;
   logic        load_err;
   logic [63:0] cap_val;

   assign out_take     = !out_v_ff || rsp_if.ready;
   assign move         = done_v_ff && out_take;
   assign room         = !done_v_ff || out_take;
   assign byte_last    = (lane_ff == FIELD_LAST_LANE[k_ff]);
   assign slot_claimed = rd_v_ff && cap_last_ff;
   // hold a field's last byte back while the previous field still lands
   assign step         = room && !(byte_last && slot_claimed);
   assign cap_val   = (cap_lane_ff == 3'd0) ? 64'(rd_data)
                                            : (acc_ff | (64'(rd_data) << {cap_lane_ff, 3'b000}));

   assign rsp_if.valid = out_v_ff;
   assign rsp_if.data  = out_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty && !q_head.err) state_in = BK_STREAM;
         end
         BK_STREAM: begin
            if (step && byte_last && (k_ff == LAST_FIELD_INDEX)) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      issue    = 1'b0;
      load_err = 1'b0;
      q_pop    = 1'b0;
      rel      = '{valid: 1'b0, bank: bank_ff};
      bank_in  = bank_ff;
      k_in     = k_ff;
      lane_in  = lane_ff;
      rd_addr  = {bank_ff, AW'(FIELD_OFFSET[k_ff]) + AW'(lane_ff)};

      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               if (q_head.err) begin
                  // wait until the last field of the previous frame has landed
                  load_err = room && !rd_v_ff;
                  q_pop    = load_err;
               end else begin
                  q_pop   = 1'b1;
                  bank_in = q_head.bank;
                  k_in    = 5'd0;
                  lane_in = 3'd0;
               end
            end
         end
         BK_STREAM: begin
            issue = step;
            if (step) begin
               if (byte_last) begin
                  k_in    = k_ff + 5'd1;
                  lane_in = 3'd0;
                  rel     = '{valid: (k_ff == LAST_FIELD_INDEX), bank: bank_ff};
               end else begin
                  lane_in = lane_ff + 3'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rd_v_in     = issue;
      cap_k_in    = k_ff;
      cap_lane_in = lane_ff;
      cap_last_in = byte_last;
      acc_in      = rd_v_ff ? cap_val : acc_ff;

      done_in   = done_ff;
      done_v_in = move ? 1'b0 : done_v_ff;
      if (rd_v_ff && cap_last_ff) begin
         done_in   = '{field_index: cap_k_ff, field_value: cap_val,
                       checksum_error: 1'b0,
                       last_field: (cap_k_ff == LAST_FIELD_INDEX)};
         done_v_in = 1'b1;
      end else if (load_err) begin
         done_in   = '{field_index: 5'd0, field_value: 64'd0,
                       checksum_error: 1'b1, last_field: 1'b1};
         done_v_in = 1'b1;
      end

      out_in   = move ? done_ff : out_ff;
      out_v_in = move ? 1'b1 : (rsp_if.ready ? 1'b0 : out_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         rd_v_ff   <= 1'b0;
         done_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_v_ff   <= rd_v_in;
         done_v_ff <= done_v_in;
         out_v_ff  <= out_v_in;
      end
      bank_ff     <= bank_in;
      k_ff        <= k_in;
      lane_ff     <= lane_in;
      cap_k_ff    <= cap_k_in;
      cap_lane_ff <= cap_lane_in;
      cap_last_ff <= cap_last_in;
      acc_ff      <= acc_in;
      done_ff     <= done_in;
      out_ff      <= out_in;
   end

endmodule

[hdl/nav_frame_deframer.sv]
// ----------------------------------------------------------------------------
// nav_frame_deframer - binary navigation frame deframer
// Header hunt, XOR check and field extraction of fixed-length frames.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle on req_if. After the header 23 5A 48
// it collects a frame of FRAME_BYTES bytes into one of two frame banks while
// the other bank is read out. A good frame yields 25 field results in frame
// order on rsp_if, the last one flagged; a bad checksum yields one error
// result. Readout streams the 82 field bytes out of the frame RAM one byte
// per cycle while the result path has room, idling whenever a field's last
// byte directly follows the previous field's last byte (seven times per
// frame) and while it fetches the frame; with rsp_if always ready this keeps
// pace with good frames sent back to back, so input runs at one byte per
// cycle as long as the consumer keeps up; the input stalls only while both
// banks hold frames not yet read out or two frame verdicts wait in the
// descriptor queue.
module nav_frame_deframer import ndf_pkg::*; #(
   parameter int FRAME_BYTES   = 90,
   parameter int CHECKED_BYTES = 87
) (
   input  logic          clock,
   input  logic          reset,
   ndf_stream_if.sink    req_if,
   ndf_stream_if.source  rsp_if
);

   localparam int ADDR_W = $clog2(FRAME_BYTES) + 1;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              push_en;
   frame_desc_type    push_desc;
   logic              q_full;
   logic              q_empty;
   logic              q_pop;
   frame_desc_type    q_head;
   bank_release_type  rel;

   ndf_front #(
      .FRAME_BYTES   (FRAME_BYTES),
      .CHECKED_BYTES (CHECKED_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .push_en   (push_en),
      .push_desc (push_desc),
      .q_full    (q_full),
      .rel       (rel)
   );

   ndf_ram #(
      .WIDTH (8),
      .DEPTH (2 ** ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ndf_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (push_en),
      .push_desc (push_desc),
      .pop_en    (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   ndf_back #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .rel     (rel),
      .rsp_if  (rsp_if)
   );

endmodule
